FILE: rtl/core/mpq_pkg.sv
// shared constants and control types for the max priority queue
`default_nettype none

package mpq_pkg;

  localparam int DATA_W           = 32;
  localparam int COUNT_OUT_W      = 7;
  localparam int DEFAULT_CAPACITY = 64;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;
  localparam logic signed [DATA_W-1:0] INSERT_VALUE = 32'sd0;

  typedef struct packed {
    logic take;
    logic start;
    logic up_issue;
    logic up_step;
    logic dn_load;
    logic dn_issue;
    logic dn_step;
    logic emit;
  } mpq_cmd_t;

  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic pos_zero;
    logic up_stop;
    logic dn_stop;
    logic out_free;
  } mpq_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/mpq_ifs.sv
// valid/ready channel interfaces for queue commands and results
`default_nettype none

interface mpq_cmd_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface mpq_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic               underflow;
  logic               overflow;
  logic               now_empty;
  logic [6:0]         item_count;

  modport source (output valid, output out_value, output underflow, output overflow,
                  output now_empty, output item_count, input ready);
  modport sink   (input valid, input out_value, input underflow, input overflow,
                  input now_empty, input item_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/max_priority_queue.sv
// max priority queue top level: binary max-heap in a single memory
// insert: start, then a parent read and a compare with write per level until the climb stops
// remove: start, load of root and last entry, then child reads and a compare-write per level
// one transaction at a time; the next command is accepted only after the result is registered
// each heap level costs one registered memory read (both children at once on the way down) and one compare with write
// sync reset empties the queue (count to zero); heap memory is not cleared
`default_nettype none

module max_priority_queue #(
  parameter int CAPACITY = mpq_pkg::DEFAULT_CAPACITY
) (
  input wire logic  clk,
  input wire logic  rst,
  mpq_cmd_if.sink   cmd_ch,
  mpq_res_if.source res_ch
);
  import mpq_pkg::*;

  mpq_cmd_t  cmd;
  mpq_stat_t stat;

  mpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd_ch.valid),
    .in_ready (cmd_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_command     (cmd_ch.command),
    .in_value       (cmd_ch.value),
    .out_valid      (res_ch.valid),
    .out_ready      (res_ch.ready),
    .out_value      (res_ch.out_value),
    .out_underflow  (res_ch.underflow),
    .out_overflow   (res_ch.overflow),
    .out_now_empty  (res_ch.now_empty),
    .out_item_count (res_ch.item_count)
  );

endmodule

`default_nettype wire

FILE: rtl/core/mpq_ctrl.sv
// sequencing state machine for heap insert and remove
`default_nettype none

module mpq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mpq_pkg::mpq_stat_t stat,
  output mpq_pkg::mpq_cmd_t      cmd
);
  import mpq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_START   = 3'd1;
  localparam logic [2:0] S_UP_RD   = 3'd2;
  localparam logic [2:0] S_UP_CMP  = 3'd3;
  localparam logic [2:0] S_DN_LOAD = 3'd4;
  localparam logic [2:0] S_DN_RD   = 3'd5;
  localparam logic [2:0] S_DN_CMP  = 3'd6;
  localparam logic [2:0] S_FINISH  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        if (stat.is_remove) begin
          state_next = stat.empty ? S_FINISH : S_DN_LOAD;
        end else begin
          state_next = stat.full ? S_FINISH : S_UP_RD;
        end
      end
      S_UP_RD: begin
        cmd.up_issue = 1'b1;
        state_next   = stat.pos_zero ? S_FINISH : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd.up_step = 1'b1;
        state_next  = stat.up_stop ? S_FINISH : S_UP_RD;
      end
      S_DN_LOAD: begin
        cmd.dn_load = 1'b1;
        state_next  = stat.empty ? S_FINISH : S_DN_RD;
      end
      S_DN_RD: begin
        cmd.dn_issue = 1'b1;
        state_next   = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.dn_step = 1'b1;
        state_next  = stat.dn_stop ? S_FINISH : S_DN_RD;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/mpq_datapath.sv
// heap memory, count, sift registers and result register
`default_nettype none

module mpq_datapath #(
  parameter int CAPACITY = mpq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire mpq_pkg::mpq_cmd_t                 cmd,
  output mpq_pkg::mpq_stat_t                     stat,
  input  wire logic                              in_command,
  input  wire logic signed [mpq_pkg::DATA_W-1:0] in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [mpq_pkg::DATA_W-1:0]      out_value,
  output logic                                   out_underflow,
  output logic                                   out_overflow,
  output logic                                   out_now_empty,
  output logic [mpq_pkg::COUNT_OUT_W-1:0]        out_item_count
);
  import mpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = AW + 2;

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd0;
  logic signed [DATA_W-1:0] rd1;

  logic                     op;
  logic signed [DATA_W-1:0] hold;
  logic signed [DATA_W-1:0] res;
  logic                     under;
  logic                     over;
  logic [CW-1:0]            cnt;
  logic [AW-1:0]            pos;

  logic [CW-1:0]            cnt_m1;
  logic [CW+COUNT_OUT_W-1:0] cnt_wide;
  logic [AW-1:0]            parent;
  logic [PW-1:0]            left;
  logic [PW-1:0]            right;
  logic [PW-1:0]            cnt_ext;
  logic                     lv;
  logic                     rv;
  logic                     take_left;
  logic                     take_right;
  logic signed [DATA_W-1:0] left_best;
  logic [AW-1:0]            rd_addr0;
  logic [AW-1:0]            rd_addr1;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  assign cnt_m1   = cnt - 1'b1;
  assign cnt_wide = {{COUNT_OUT_W{1'b0}}, cnt};
  assign parent   = (pos - 1'b1) >> 1;
  assign left     = {1'b0, pos, 1'b1};
  assign right    = left + 1'b1;
  assign cnt_ext  = {{(PW-CW){1'b0}}, cnt};
  assign lv       = left < cnt_ext;
  assign rv       = right < cnt_ext;

  assign take_left  = lv && (rd0 > hold);
  assign left_best  = take_left ? rd0 : hold;
  assign take_right = rv && (rd1 > left_best);

  assign stat.is_remove = (op == CMD_REMOVE);
  assign stat.full      = cnt >= CW'(CAPACITY);
  assign stat.empty     = (cnt == '0);
  assign stat.pos_zero  = (pos == '0);
  assign stat.up_stop   = rd0 >= hold;
  assign stat.dn_stop   = !take_left && !take_right;
  assign stat.out_free  = !out_valid || out_ready;

  always_comb begin
    rd_addr0 = '0;
    rd_addr1 = '0;
    wr_en    = 1'b0;
    wr_addr  = pos;
    wr_data  = hold;
    if (cmd.start) begin
      rd_addr1 = cnt_m1[AW-1:0];
    end
    if (cmd.up_issue) begin
      rd_addr0 = parent;
      if (stat.pos_zero) begin
        wr_en = 1'b1;
      end
    end
    if (cmd.up_step) begin
      wr_en   = 1'b1;
      wr_data = stat.up_stop ? hold : rd0;
    end
    if (cmd.dn_issue) begin
      rd_addr0 = lv ? left[AW-1:0] : '0;
      rd_addr1 = rv ? right[AW-1:0] : '0;
    end
    if (cmd.dn_step) begin
      wr_en   = 1'b1;
      wr_data = take_right ? rd1 : left_best;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd0 <= mem[rd_addr0];
    rd1 <= mem[rd_addr1];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op   <= in_command;
      hold <= in_value;
    end
    if (cmd.start) begin
      res   <= (op == CMD_REMOVE && stat.empty) ? EMPTY_VALUE : INSERT_VALUE;
      under <= (op == CMD_REMOVE) && stat.empty;
      over  <= (op == CMD_INSERT) && stat.full;
      if (op == CMD_INSERT) begin
        pos <= cnt[AW-1:0];
      end
    end
    if (cmd.up_step && !stat.up_stop) begin
      pos <= parent;
    end
    if (cmd.dn_load) begin
      res  <= rd0;
      hold <= rd1;
      pos  <= '0;
    end
    if (cmd.dn_step && !stat.dn_stop) begin
      pos <= take_right ? right[AW-1:0] : left[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.start) begin
      if (op == CMD_REMOVE && !stat.empty) begin
        cnt <= cnt_m1;
      end else if (op == CMD_INSERT && !stat.full) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value      <= res;
      out_underflow  <= under;
      out_overflow   <= over;
      out_now_empty  <= stat.empty;
      out_item_count <= cnt_wide[COUNT_OUT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_underflow && out_overflow))
    else $error("underflow and overflow both set");

  a_under_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_underflow |-> out_value == EMPTY_VALUE && out_now_empty)
    else $error("underflow result malformed");

  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.start && op == CMD_REMOVE && !stat.empty |=> cnt == $past(cnt_m1))
    else $error("remove did not decrement count");

  a_no_emit_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid || out_ready)
    else $error("result overwritten before transaction");
`endif

endmodule

`default_nettype wire
